### sv/epp_pkg.sv
`default_nettype none

package epp_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int DET_THR_W = 32;
	localparam int SCALE_THR_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DET_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_THR = 2'd1;

	// Magnitudes are brought below 2**NORM_BITS before the roots.
	localparam int NORM_BITS = 30;

	localparam int ANGLE_W = 19;
	localparam int ANGLE_ZW = 20;
	localparam int ANGLE_MAX = 205887;
	localparam int HALF_PI_Q16 = 102944;
	localparam int CORDIC_STEPS = 17;

	function automatic logic signed [ANGLE_ZW-1:0] atan_q16(input int i);
		case (i)
			0: return ANGLE_ZW'(51472);
			1: return ANGLE_ZW'(30385);
			2: return ANGLE_ZW'(16055);
			3: return ANGLE_ZW'(8150);
			4: return ANGLE_ZW'(4091);
			5: return ANGLE_ZW'(2047);
			6: return ANGLE_ZW'(1024);
			7: return ANGLE_ZW'(512);
			8: return ANGLE_ZW'(256);
			9: return ANGLE_ZW'(128);
			10: return ANGLE_ZW'(64);
			11: return ANGLE_ZW'(32);
			12: return ANGLE_ZW'(16);
			13: return ANGLE_ZW'(8);
			14: return ANGLE_ZW'(4);
			15: return ANGLE_ZW'(2);
			16: return ANGLE_ZW'(1);
			default: return '0;
		endcase
	endfunction

endpackage

`default_nettype wire

### sv/ellipse_parametric_projection.sv
// Ellipse parametric projection.
// Each input transfer carries an ellipse center, a major-axis end point, a minor-axis
// end point and a cursor, all signed fixed point. The block solves the cursor in the
// semi-axis basis, normalizes the solution to unit length and returns the ellipse point
// at that parametric angle, together with the angle itself in Q3.16 radians.
// Input and output channels use valid and ready; the configuration channel is always
// ready and writes the determinant threshold (index 0) or the scale threshold (index 1).
// Other indexes are ignored.
// From an input transfer to its result the pipeline holds eight setup stages, one stage
// per bit of the 31-bit square roots, one stage for the scale test, one stage per quotient
// bit of the normalizing dividers (FRAC_BITS + 1), and three stages for the point.
// One item is accepted in every cycle while the receiver does not stall. When it stalls,
// the whole pipeline holds and in_ready falls until the output register is emptied.
// Reset clears both thresholds and all valid bits; the pipeline is empty after reset.

`default_nettype none

module ellipse_parametric_projection #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [epp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [epp_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic signed [COORD_WIDTH-1:0] center_x,
	input logic signed [COORD_WIDTH-1:0] center_y,
	input logic signed [COORD_WIDTH-1:0] major_px,
	input logic signed [COORD_WIDTH-1:0] major_py,
	input logic signed [COORD_WIDTH-1:0] minor_px,
	input logic signed [COORD_WIDTH-1:0] minor_py,
	input logic signed [COORD_WIDTH-1:0] cursor_px,
	input logic signed [COORD_WIDTH-1:0] cursor_py,
	output logic out_valid,
	input logic out_ready,
	output logic valid_res,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y,
	output logic signed [epp_pkg::ANGLE_W-1:0] angle
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;
	localparam int NW = PW + 1;
	localparam int LW = $clog2(NW + 1);
	localparam int NB = epp_pkg::NORM_BITS;
	localparam int SQW = 2 * NB + 1;
	localparam int RTW = (SQW + 1) / 2;
	localparam int TDW = epp_pkg::SCALE_THR_W + NB;
	localparam int CMPW = (RTW + FRAC_BITS > TDW) ? RTW + FRAC_BITS : TDW;
	localparam int XW = NB + 4;
	localparam int ZW = epp_pkg::ANGLE_ZW;
	localparam int AW = epp_pkg::ANGLE_W;
	localparam int QW = FRAC_BITS + 1;
	localparam int NUMW = FRAC_BITS + NB + 2;
	localparam int DENW = RTW + 1;
	localparam int CSW = QW + 1;
	localparam int MPW = DW + CSW;
	localparam int SMW = MPW + 1;
	localparam int TW = SMW - FRAC_BITS;
	localparam int OW = TW + 1;

	localparam logic signed [SMW-1:0] RND = SMW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [OW-1:0] SAT_HI = (OW'(1) <<< (COORD_WIDTH - 1)) - OW'(1);
	localparam logic signed [OW-1:0] SAT_LO = ~SAT_HI;
	localparam logic signed [ZW-1:0] Z_MAX = ZW'(epp_pkg::ANGLE_MAX);
	localparam logic signed [ZW-1:0] Z_HALF_PI = ZW'(epp_pkg::HALF_PI_Q16);

	typedef struct packed {
		logic signed [DW-1:0] ax;
		logic signed [DW-1:0] ay;
		logic signed [DW-1:0] bx;
		logic signed [DW-1:0] by;
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
	} geo_t;

	typedef struct packed {
		geo_t geo;
		logic [NB-1:0] a2m;
		logic [NB-1:0] b2m;
		logic cneg;
		logic sneg;
		logic det_bad;
		logic [TDW-1:0] thrd;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} mid_t;

	typedef struct packed {
		geo_t geo;
		logic cneg;
		logic sneg;
		logic bad;
		logic signed [AW-1:0] ang;
	} side_t;

	logic en;
	logic [epp_pkg::DET_THR_W-1:0] det_thr_q;
	logic [epp_pkg::SCALE_THR_W-1:0] scale_thr_q;

	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_thr_q <= '0;
			scale_thr_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				epp_pkg::REG_DET_THR: det_thr_q <= cfg_data[epp_pkg::DET_THR_W-1:0];
				epp_pkg::REG_SCALE_THR: scale_thr_q <= cfg_data[epp_pkg::SCALE_THR_W-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [LW-1:0] bit_len(input logic [NW-1:0] v);
		logic [LW-1:0] n;
		n = '0;
		for (int i = 0; i < NW; i++) begin
			if (v[i]) n = LW'(i + 1);
		end
		return n;
	endfunction

	function automatic logic [LW-1:0] norm_shift(input logic [NW-1:0] v);
		logic [LW-1:0] n;
		n = bit_len(v);
		return (n > LW'(NB)) ? n - LW'(NB) : '0;
	endfunction

	// Valid bits of the fixed stages.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic [RTW-1:0] v_mid;
	logic [QW-1:0] v_div;

	// Stage 1: axis and cursor vectors relative to the center.
	geo_t geo_s1;
	logic signed [DW-1:0] ux_s1, uy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1.ax <= DW'(major_px) - DW'(center_x);
			geo_s1.ay <= DW'(major_py) - DW'(center_y);
			geo_s1.bx <= DW'(minor_px) - DW'(center_x);
			geo_s1.by <= DW'(minor_py) - DW'(center_y);
			geo_s1.cx <= center_x;
			geo_s1.cy <= center_y;
			ux_s1 <= DW'(cursor_px) - DW'(center_x);
			uy_s1 <= DW'(cursor_py) - DW'(center_y);
		end
	end

	// Stage 2: cross products.
	geo_t geo_s2;
	logic signed [PW-1:0] axby_s2, aybx_s2, uxby_s2, uybx_s2, axuy_s2, ayux_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s2 <= geo_s1;
			axby_s2 <= PW'(geo_s1.ax) * PW'(geo_s1.by);
			aybx_s2 <= PW'(geo_s1.ay) * PW'(geo_s1.bx);
			uxby_s2 <= PW'(ux_s1) * PW'(geo_s1.by);
			uybx_s2 <= PW'(uy_s1) * PW'(geo_s1.bx);
			axuy_s2 <= PW'(geo_s1.ax) * PW'(uy_s1);
			ayux_s2 <= PW'(geo_s1.ay) * PW'(ux_s1);
		end
	end

	// Stage 3: determinant and the two numerators.
	geo_t geo_s3;
	logic signed [NW-1:0] det_s3, nc_s3, ns_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s3 <= geo_s2;
			det_s3 <= NW'(axby_s2) - NW'(aybx_s2);
			nc_s3 <= NW'(uxby_s2) - NW'(uybx_s2);
			ns_s3 <= NW'(axuy_s2) - NW'(ayux_s2);
		end
	end

	// Stage 4: fold the determinant sign into the numerators and take magnitudes.
	geo_t geo_s4;
	logic [NW-1:0] adet_s4, anc_s4, ans_s4;
	logic cneg_s4, sneg_s4;
	logic signed [NW-1:0] ncf, nsf;

	always_comb begin
		ncf = det_s3[NW-1] ? -nc_s3 : nc_s3;
		nsf = det_s3[NW-1] ? -ns_s3 : ns_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s4 <= geo_s3;
			adet_s4 <= det_s3[NW-1] ? -det_s3 : det_s3;
			anc_s4 <= ncf[NW-1] ? -ncf : ncf;
			ans_s4 <= nsf[NW-1] ? -nsf : nsf;
			cneg_s4 <= ncf[NW-1];
			sneg_s4 <= nsf[NW-1];
		end
	end

	// Stage 5: normalizing shift amounts and the determinant test.
	geo_t geo_s5;
	logic [NW-1:0] adet_s5, anc_s5, ans_s5;
	logic cneg_s5, sneg_s5, det_bad_s5;
	logic [LW-1:0] sh_full_s5, sh_dir_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s5 <= geo_s4;
			adet_s5 <= adet_s4;
			anc_s5 <= anc_s4;
			ans_s5 <= ans_s4;
			cneg_s5 <= cneg_s4;
			sneg_s5 <= sneg_s4;
			det_bad_s5 <= adet_s4 <= NW'(det_thr_q);
			sh_full_s5 <= norm_shift(adet_s4 | anc_s4 | ans_s4);
			sh_dir_s5 <= norm_shift(anc_s4 | ans_s4);
		end
	end

	// Stage 6: shifted magnitudes.
	geo_t geo_s6;
	logic [NB-1:0] a_s6, b_s6, d_s6, a2m_s6, b2m_s6;
	logic cneg_s6, sneg_s6, det_bad_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s6 <= geo_s5;
			a_s6 <= NB'(anc_s5 >> sh_full_s5);
			b_s6 <= NB'(ans_s5 >> sh_full_s5);
			d_s6 <= NB'(adet_s5 >> sh_full_s5);
			a2m_s6 <= NB'(anc_s5 >> sh_dir_s5);
			b2m_s6 <= NB'(ans_s5 >> sh_dir_s5);
			cneg_s6 <= cneg_s5;
			sneg_s6 <= sneg_s5;
			det_bad_s6 <= det_bad_s5;
		end
	end

	// Stage 7: squares, scaled threshold and the quadrant pre-rotation.
	logic [2*NB-1:0] aa_s7, bb_s7, cc_s7, dd_s7;
	mid_t pre_s7;
	logic signed [XW-1:0] xa, yb;

	always_comb begin
		xa = cneg_s6 ? -XW'(a2m_s6) : XW'(a2m_s6);
		yb = sneg_s6 ? -XW'(b2m_s6) : XW'(b2m_s6);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s7 <= (2 * NB)'(a_s6) * (2 * NB)'(a_s6);
			bb_s7 <= (2 * NB)'(b_s6) * (2 * NB)'(b_s6);
			cc_s7 <= (2 * NB)'(a2m_s6) * (2 * NB)'(a2m_s6);
			dd_s7 <= (2 * NB)'(b2m_s6) * (2 * NB)'(b2m_s6);
			pre_s7.geo <= geo_s6;
			pre_s7.a2m <= a2m_s6;
			pre_s7.b2m <= b2m_s6;
			pre_s7.cneg <= cneg_s6;
			pre_s7.sneg <= sneg_s6;
			pre_s7.det_bad <= det_bad_s6;
			pre_s7.thrd <= TDW'(scale_thr_q) * TDW'(d_s6);
			if (!xa[XW-1]) begin
				pre_s7.x <= xa;
				pre_s7.y <= yb;
				pre_s7.z <= '0;
			end else if (!yb[XW-1]) begin
				pre_s7.x <= yb;
				pre_s7.y <= -xa;
				pre_s7.z <= Z_HALF_PI;
			end else begin
				pre_s7.x <= -yb;
				pre_s7.y <= xa;
				pre_s7.z <= -Z_HALF_PI;
			end
		end
	end

	// Stage 8: sums of squares.
	logic [SQW-1:0] sum_full_s8, sum_dir_s8;
	mid_t mid_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_full_s8 <= SQW'(aa_s7) + SQW'(bb_s7);
			sum_dir_s8 <= SQW'(cc_s7) + SQW'(dd_s7);
			mid_s8 <= pre_s7;
		end
	end

	// Square root stages, with the angle rotations running alongside.
	logic [RTW-1:0] h_full, h_dir;
	mid_t mid_sn [RTW];

	epp_isqrt #(.IN_W(SQW)) u_sqrt_full (
		.clk(clk),
		.en(en),
		.rad(sum_full_s8),
		.root(h_full)
	);

	epp_isqrt #(.IN_W(SQW)) u_sqrt_dir (
		.clk(clk),
		.en(en),
		.rad(sum_dir_s8),
		.root(h_dir)
	);

	for (genvar k = 0; k < RTW; k++) begin : g_mid
		mid_t src;
		mid_t nxt;

		if (k == 0) begin : g_first
			assign src = mid_s8;
		end else begin : g_next
			assign src = mid_sn[k-1];
		end

		always_comb begin
			nxt = src;
			if (k < epp_pkg::CORDIC_STEPS) begin
				if (!src.y[XW-1]) begin
					nxt.x = src.x + (src.y >>> k);
					nxt.y = src.y - (src.x >>> k);
					nxt.z = src.z + epp_pkg::atan_q16(k);
				end else begin
					nxt.x = src.x - (src.y >>> k);
					nxt.y = src.y + (src.x >>> k);
					nxt.z = src.z - epp_pkg::atan_q16(k);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) mid_sn[k] <= nxt;
		end
	end

	// Stage 9: scale test, divider operands and angle clamp.
	mid_t mid_end;
	side_t side_s9;
	logic [NUMW-1:0] num_c_s9, num_s_s9;
	logic [DENW-1:0] den_s9;
	logic scale_bad;

	assign mid_end = mid_sn[RTW-1];
	assign scale_bad = (CMPW'(h_full) << FRAC_BITS) <= CMPW'(mid_end.thrd);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s9.geo <= mid_end.geo;
			side_s9.cneg <= mid_end.cneg;
			side_s9.sneg <= mid_end.sneg;
			side_s9.bad <= mid_end.det_bad || scale_bad || (h_dir == '0);
			if (mid_end.z > Z_MAX) begin
				side_s9.ang <= AW'(Z_MAX);
			end else if (mid_end.z < -Z_MAX) begin
				side_s9.ang <= AW'(-Z_MAX);
			end else begin
				side_s9.ang <= AW'(mid_end.z);
			end
			num_c_s9 <= (NUMW'(mid_end.a2m) << (FRAC_BITS + 1)) + NUMW'(h_dir);
			num_s_s9 <= (NUMW'(mid_end.b2m) << (FRAC_BITS + 1)) + NUMW'(h_dir);
			den_s9 <= {h_dir, 1'b0};
		end
	end

	// Divider stages for the unit cosine and sine.
	logic [QW-1:0] cq, sq;
	side_t side_sn [QW];

	epp_div #(.NUM_W(NUMW), .DEN_W(DENW), .Q_W(QW)) u_div_cos (
		.clk(clk),
		.en(en),
		.num(num_c_s9),
		.den(den_s9),
		.quo(cq)
	);

	epp_div #(.NUM_W(NUMW), .DEN_W(DENW), .Q_W(QW)) u_div_sin (
		.clk(clk),
		.en(en),
		.num(num_s_s9),
		.den(den_s9),
		.quo(sq)
	);

	for (genvar k = 0; k < QW; k++) begin : g_side
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) side_sn[k] <= side_s9;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) side_sn[k] <= side_sn[k-1];
			end
		end
	end

	// Stage 10: axis contributions.
	side_t side_end;
	logic signed [CSW-1:0] cs, sn;
	logic signed [MPW-1:0] pax_s10, pbx_s10, pay_s10, pby_s10;
	logic signed [COORD_WIDTH-1:0] cx_s10, cy_s10;
	logic bad_s10;
	logic signed [AW-1:0] ang_s10;

	assign side_end = side_sn[QW-1];

	always_comb begin
		cs = side_end.cneg ? -signed'(CSW'(cq)) : signed'(CSW'(cq));
		sn = side_end.sneg ? -signed'(CSW'(sq)) : signed'(CSW'(sq));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pax_s10 <= MPW'(side_end.geo.ax) * MPW'(cs);
			pbx_s10 <= MPW'(side_end.geo.bx) * MPW'(sn);
			pay_s10 <= MPW'(side_end.geo.ay) * MPW'(cs);
			pby_s10 <= MPW'(side_end.geo.by) * MPW'(sn);
			cx_s10 <= side_end.geo.cx;
			cy_s10 <= side_end.geo.cy;
			bad_s10 <= side_end.bad;
			ang_s10 <= side_end.ang;
		end
	end

	// Stage 11: rounded offsets from the center.
	logic signed [SMW-1:0] sumx, sumy;
	logic signed [TW-1:0] tx_s11, ty_s11;
	logic signed [COORD_WIDTH-1:0] cx_s11, cy_s11;
	logic bad_s11;
	logic signed [AW-1:0] ang_s11;

	always_comb begin
		sumx = SMW'(pax_s10) + SMW'(pbx_s10) + RND;
		sumy = SMW'(pay_s10) + SMW'(pby_s10) + RND;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s11 <= TW'(sumx >>> FRAC_BITS);
			ty_s11 <= TW'(sumy >>> FRAC_BITS);
			cx_s11 <= cx_s10;
			cy_s11 <= cy_s10;
			bad_s11 <= bad_s10;
			ang_s11 <= ang_s10;
		end
	end

	// Output register: saturated point.
	logic signed [OW-1:0] px, py;
	logic out_valid_q, valid_res_q;
	logic signed [COORD_WIDTH-1:0] point_x_q, point_y_q;
	logic signed [AW-1:0] angle_q;

	always_comb begin
		px = OW'(cx_s11) + OW'(tx_s11);
		py = OW'(cy_s11) + OW'(ty_s11);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			valid_res_q <= !bad_s11;
			if (bad_s11) begin
				point_x_q <= '0;
				point_y_q <= '0;
				angle_q <= '0;
			end else begin
				point_x_q <= (px > SAT_HI) ? COORD_WIDTH'(SAT_HI) :
					(px < SAT_LO) ? COORD_WIDTH'(SAT_LO) : COORD_WIDTH'(px);
				point_y_q <= (py > SAT_HI) ? COORD_WIDTH'(SAT_HI) :
					(py < SAT_LO) ? COORD_WIDTH'(SAT_LO) : COORD_WIDTH'(py);
				angle_q <= ang_s11;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_mid <= '0;
			v_s9 <= 1'b0;
			v_div <= '0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_mid <= {v_mid[RTW-2:0], v_s8};
			v_s9 <= v_mid[RTW-1];
			v_div <= {v_div[QW-2:0], v_s9};
			v_s10 <= v_div[QW-1];
			v_s11 <= v_s10;
			out_valid_q <= v_s11;
		end
	end

	assign out_valid = out_valid_q;
	assign valid_res = valid_res_q;
	assign point_x = point_x_q;
	assign point_y = point_y_q;
	assign angle = angle_q;

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> point_x == '0 && point_y == '0 && angle == '0)
		else $error("invalid result carries nonzero payload");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle <= epp_pkg::ANGLE_MAX && angle >= -epp_pkg::ANGLE_MAX)
		else $error("angle out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_mid) && $stable(v_div) && $stable(v_s1))
		else $error("pipeline moved during a stall");

	a_good_has_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 && !side_s9.bad |-> den_s9 != '0)
		else $error("valid item with zero divisor");

endmodule

`default_nettype wire

### sv/epp_isqrt.sv
`default_nettype none

module epp_isqrt #(
	parameter int IN_W = 61
) (
	input logic clk,
	input logic en,
	input logic [IN_W-1:0] rad,
	output logic [(IN_W+1)/2-1:0] root
);

	localparam int RT_W = (IN_W + 1) / 2;
	localparam int RW = IN_W + 1;

	logic [RW-1:0] rem_sn [RT_W];
	logic [RW-1:0] acc_sn [RT_W];

	for (genvar k = 0; k < RT_W; k++) begin : g_step
		logic [RW-1:0] src_rem;
		logic [RW-1:0] src_acc;
		logic [RW-1:0] trial;
		logic [RW-1:0] nxt_rem;
		logic [RW-1:0] nxt_acc;
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (RT_W - 1 - k));

		if (k == 0) begin : g_first
			assign src_rem = RW'(rad);
			assign src_acc = '0;
		end else begin : g_next
			assign src_rem = rem_sn[k-1];
			assign src_acc = acc_sn[k-1];
		end

		always_comb begin
			trial = src_acc + BIT;
			if (src_rem >= trial) begin
				nxt_rem = src_rem - trial;
				nxt_acc = (src_acc >> 1) + BIT;
			end else begin
				nxt_rem = src_rem;
				nxt_acc = src_acc >> 1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sn[k] <= nxt_rem;
				acc_sn[k] <= nxt_acc;
			end
		end
	end

	assign root = RT_W'(acc_sn[RT_W-1]);

endmodule

`default_nettype wire

### sv/epp_div.sv
`default_nettype none

module epp_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 32,
	parameter int Q_W = 17
) (
	input logic clk,
	input logic en,
	input logic [NUM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	output logic [Q_W-1:0] quo
);

	localparam int TW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic [TW-1:0] rem_sn [Q_W];
	logic [DEN_W-1:0] den_sn [Q_W];
	logic [Q_W-1:0] quo_sn [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [TW-1:0] src_rem;
		logic [DEN_W-1:0] src_den;
		logic [Q_W-1:0] src_quo;
		logic [TW-1:0] trial;
		logic [TW-1:0] nxt_rem;
		logic [Q_W-1:0] nxt_quo;

		if (k == 0) begin : g_first
			assign src_rem = TW'(num);
			assign src_den = den;
			assign src_quo = '0;
		end else begin : g_next
			assign src_rem = rem_sn[k-1];
			assign src_den = den_sn[k-1];
			assign src_quo = quo_sn[k-1];
		end

		always_comb begin
			trial = TW'(src_den) << (Q_W - 1 - k);
			nxt_rem = src_rem;
			nxt_quo = src_quo;
			if (src_rem >= trial) begin
				nxt_rem = src_rem - trial;
				nxt_quo[Q_W-1-k] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sn[k] <= nxt_rem;
				den_sn[k] <= src_den;
				quo_sn[k] <= nxt_quo;
			end
		end
	end

	assign quo = quo_sn[Q_W-1];

endmodule

`default_nettype wire

### tb/sv/tb.sv
`default_nettype none

module tb;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int PIPE_LAT = 44 + FB;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [epp_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 2'd2;
	localparam logic [epp_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 2'd3;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [CW-1:0] cx, cy, mx, my, nx, ny, px, py;
	} ellipse_item_t;

	typedef struct {
		logic valid;
		logic signed [CW-1:0] x, y;
		logic signed [epp_pkg::ANGLE_W-1:0] ang;
	} projection_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [epp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [epp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic valid_res;
	logic signed [CW-1:0] point_x, point_y;
	logic signed [epp_pkg::ANGLE_W-1:0] angle;
	ellipse_item_t cur = '{default: '0};

	ellipse_item_t pending[$];
	projection_t expected_proj[$];
	logic [epp_pkg::DET_THR_W-1:0] det_limit = '0;
	logic [epp_pkg::SCALE_THR_W-1:0] scale_limit = '0;
	int errors = 0;
	int n_results = 0;
	int n_valid = 0;
	int cycles = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int burst_left = 0;
	int gap_left = 0;
	int rx_mode = 0;
	int rx_period = 1;
	int rx_cnt = 0;

	always #5 clk = ~clk;

	ellipse_parametric_projection #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.center_x(cur.cx), .center_y(cur.cy), .major_px(cur.mx), .major_py(cur.my),
		.minor_px(cur.nx), .minor_py(cur.ny), .cursor_px(cur.px), .cursor_py(cur.py),
		.out_valid(out_valid), .out_ready(out_ready), .valid_res(valid_res),
		.point_x(point_x), .point_y(point_y), .angle(angle)
	);

	function automatic int bit_length(wide_t v);
		int n;
		n = 0;
		for (int i = 0; i < 128; i++) if (v[i]) n = i + 1;
		return n;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unit_component(longint v, longint unsigned h);
		longint unsigned m, q;
		m = v < 0 ? -v : v;
		q = ((m << (FB + 1)) + h) / (2 * h);
		return v < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint sat_point(longint c, longint a, longint b, longint cs, longint sn);
		wide_t sum;
		longint v;
		sum = wide_t'(a) * wide_t'(cs) + wide_t'(b) * wide_t'(sn) + (wide_t'(1) <<< (FB - 1));
		sum = sum >>> FB;
		v = c + longint'(sum[63:0]);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v;
	endfunction

	function automatic longint cordic_atan2(longint x, longint y);
		longint z, t, xs, ys;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = epp_pkg::HALF_PI_Q16;
			end else begin
				t = x; x = -y; y = t; z = -epp_pkg::HALF_PI_Q16;
			end
		end
		for (int i = 0; i < epp_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + longint'(epp_pkg::atan_q16(i));
			end else begin
				x = x - ys; y = y + xs; z = z - longint'(epp_pkg::atan_q16(i));
			end
		end
		if (z > epp_pkg::ANGLE_MAX) z = epp_pkg::ANGLE_MAX;
		if (z < -epp_pkg::ANGLE_MAX) z = -epp_pkg::ANGLE_MAX;
		return z;
	endfunction

	function automatic projection_t project_cursor(ellipse_item_t it);
		longint cx, cy, ax, ay, bx, by, ux, uy, a2, b2, cs, sn, z;
		wide_t det, nc, ns, adet, anc, ans;
		int bits, s;
		longint unsigned a, b, d, h, h2;
		projection_t r;
		r = '{valid: 1'b0, x: '0, y: '0, ang: '0};
		cx = it.cx; cy = it.cy;
		ax = longint'(it.mx) - cx; ay = longint'(it.my) - cy;
		bx = longint'(it.nx) - cx; by = longint'(it.ny) - cy;
		ux = longint'(it.px) - cx; uy = longint'(it.py) - cy;
		det = wide_t'(ax) * wide_t'(by) - wide_t'(ay) * wide_t'(bx);
		nc = wide_t'(ux) * wide_t'(by) - wide_t'(uy) * wide_t'(bx);
		ns = wide_t'(ax) * wide_t'(uy) - wide_t'(ay) * wide_t'(ux);
		adet = det < 0 ? -det : det;
		if (adet <= $signed({96'b0, det_limit})) return r;
		if (det < 0) begin
			nc = -nc;
			ns = -ns;
		end
		anc = nc < 0 ? -nc : nc;
		ans = ns < 0 ? -ns : ns;
		bits = bit_length(anc);
		if (bit_length(ans) > bits) bits = bit_length(ans);
		if (bit_length(adet) > bits) bits = bit_length(adet);
		s = bits > epp_pkg::NORM_BITS ? bits - epp_pkg::NORM_BITS : 0;
		a = 64'(anc >> s);
		b = 64'(ans >> s);
		d = 64'(adet >> s);
		h = int_sqrt(a * a + b * b);
		if ((h << FB) <= 64'(scale_limit) * d) return r;
		bits = bit_length(anc);
		if (bit_length(ans) > bits) bits = bit_length(ans);
		s = bits > epp_pkg::NORM_BITS ? bits - epp_pkg::NORM_BITS : 0;
		a2 = longint'(64'(anc >> s));
		b2 = longint'(64'(ans >> s));
		if (nc < 0) a2 = -a2;
		if (ns < 0) b2 = -b2;
		h2 = int_sqrt(64'(a2 * a2) + 64'(b2 * b2));
		if (h2 == 0) return r;
		cs = unit_component(a2, h2);
		sn = unit_component(b2, h2);
		z = cordic_atan2(a2, b2);
		r.valid = 1'b1;
		r.x = CW'(sat_point(cx, ax, bx, cs, sn));
		r.y = CW'(sat_point(cy, ay, by, cs, sn));
		r.ang = epp_pkg::ANGLE_W'(z);
		return r;
	endfunction

	function automatic longint rs(int k);
		longint v;
		v = $signed({$urandom, $urandom});
		return v >>> (64 - k);
	endfunction

	function automatic ellipse_item_t mk(longint cx, longint cy, longint mx, longint my,
			longint nx, longint ny, longint px, longint py);
		ellipse_item_t it;
		it.cx = CW'(cx); it.cy = CW'(cy); it.mx = CW'(mx); it.my = CW'(my);
		it.nx = CW'(nx); it.ny = CW'(ny); it.px = CW'(px); it.py = CW'(py);
		return it;
	endfunction

	function automatic ellipse_item_t random_ellipse();
		longint cx, cy, ax, ay, k;
		cx = rs(24);
		cy = rs(24);
		ax = rs(20);
		ay = rs(20);
		case ($urandom_range(0, 9))
			6: return mk(rs(32), rs(32), rs(32), rs(32), rs(32), rs(32), rs(32), rs(32));
			7: begin
				k = rs(3);
				if ($urandom_range(0, 1))
					return mk(cx, cy, cx + ax, cy + ay, cx + k * ax, cy + k * ay,
						cx + rs(21), cy + rs(21));
				return mk(cx, cy, cx + ax, cy + ay, cx + rs(2), cy + rs(2),
					cx + rs(21), cy + rs(21));
			end
			8: return mk(cx, cy, cx + ax, cy + ay, cx - ay + rs(16), cy + ax + rs(16),
				cx + rs(2), cy + rs(2));
			9: begin
				cx = $urandom_range(0, 1) ? 2147483647 - (rs(20) & 20'hfffff)
					: -2147483648 + (rs(20) & 20'hfffff);
				cy = $urandom_range(0, 1) ? 2147483647 - (rs(20) & 20'hfffff)
					: -2147483648 + (rs(20) & 20'hfffff);
				return mk(cx, cy, cx - rs(30), cy - rs(30), cx - rs(30), cy - rs(30),
					cx - rs(31), cy - rs(31));
			end
			default: return mk(cx, cy, cx + ax, cy + ay, cx - ay + rs(18), cy + ax + rs(18),
				cx + rs(22), cy + rs(22));
		endcase
	endfunction

	task automatic add_item(ellipse_item_t it);
		pending.insert(pending.size(), it);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic fire;
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			fire = in_valid && in_ready;
			if (fire) begin
				expected_proj.insert(expected_proj.size(), project_cursor(cur));
				void'(pending.pop_front());
			end
			if (!in_valid || fire) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					cur <= pending[0];
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rx_cnt <= rx_cnt + 1;
			if (rx_cnt % 200 == 0) begin
				rx_mode <= $urandom_range(0, 3);
				rx_period <= $urandom_range(2, 6);
			end
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_left <= 500;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					2: out_ready <= (rx_cnt % rx_period) != 0;
					default: out_ready <= (rx_cnt % rx_period) == 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		projection_t e;
		if (arst_n && out_valid && out_ready) begin
			n_results <= n_results + 1;
			if (valid_res) n_valid <= n_valid + 1;
			if (expected_proj.size() == 0) begin
				errors <= errors + 1;
				if (errors < 10) $display("ERROR: result transfer with nothing expected");
			end else begin
				e = expected_proj.pop_front();
				if (valid_res !== e.valid || point_x !== e.x || point_y !== e.y
						|| angle !== e.ang) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("ERROR: expected v=%0d x=%0d y=%0d a=%0d, got v=%0d x=%0d y=%0d a=%0d",
							e.valid, e.x, e.y, e.ang, valid_res, point_x, point_y, angle);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(logic [epp_pkg::CFG_IDX_W-1:0] idx,
			logic [epp_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == epp_pkg::REG_DET_THR) det_limit = data[epp_pkg::DET_THR_W-1:0];
		else if (idx == epp_pkg::REG_SCALE_THR) scale_limit = data[epp_pkg::SCALE_THR_W-1:0];
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending.size() > 0 || in_valid || expected_proj.size() > 0) @(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	task automatic run_random(int n, bit with_hold);
		@(negedge clk);
		for (int i = 0; i < n; i++) add_item(random_ellipse());
		if (with_hold) hold_req = hold_req + 1;
		drain();
	endtask

	localparam longint ONE = 64'sd65536;
	localparam longint PMAX = 64'sd2147483647;
	localparam longint PMIN = -64'sd2147483648;

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		@(negedge clk);
		add_item(mk(0, 0, 0, 0, 0, 0, 0, 0));
		add_item(mk(0, 0, ONE, 0, 0, ONE, ONE, 0));
		add_item(mk(0, 0, ONE, 0, 0, ONE, 0, ONE));
		add_item(mk(0, 0, ONE, 0, 0, ONE, -ONE, 0));
		add_item(mk(0, 0, ONE, 0, 0, ONE, 0, -ONE));
		add_item(mk(0, 0, ONE, 0, 0, ONE, -ONE, -1));
		add_item(mk(0, 0, ONE, 0, 0, ONE, -ONE, 1));
		add_item(mk(5, 7, 3 * ONE, 7, 5, ONE, 5, 7));
		add_item(mk(0, 0, ONE, ONE, 2 * ONE, 2 * ONE, ONE, 0));
		add_item(mk(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX));
		add_item(mk(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN));
		add_item(mk(0, 0, PMAX, 0, 0, PMIN, PMIN, PMAX));
		add_item(mk(PMIN, PMAX, PMAX, PMAX, PMIN, PMIN, PMAX, PMIN));
		add_item(mk(PMAX, 0, PMIN, 0, PMAX, ONE, PMIN, 0));
		add_item(mk(PMAX - ONE, 0, 0, 0, PMAX - ONE, ONE, PMIN, 0));
		add_item(mk(PMIN + ONE, PMIN + ONE, PMAX, PMIN + ONE, PMIN + ONE, PMAX,
			PMIN, PMIN));
		add_item(mk(0, 0, ONE, 0, 0, ONE, PMAX, PMAX));
		add_item(mk(-1, -1, PMAX, PMIN, PMIN, PMAX, 0, 0));
		add_item(mk(ONE, -ONE, 3 * ONE, -ONE, ONE, ONE, ONE + 1, -ONE));
		add_item(mk(0, 0, 0, ONE, ONE, 0, ONE, ONE));
		drain();

		write_reg(epp_pkg::REG_DET_THR, 32'hffffffff);
		add_item(mk(0, 0, ONE, 0, 0, ONE, ONE, ONE));
		add_item(mk(0, 0, ONE, 0, 0, ONE + 1, ONE, ONE));
		run_random(150, 1'b1);

		write_reg(epp_pkg::REG_DET_THR, 32'd0);
		write_reg(epp_pkg::REG_SCALE_THR, 32'hffffffff);
		run_random(150, 1'b0);

		write_reg(epp_pkg::REG_DET_THR, $urandom_range(0, 32'h0000ffff));
		write_reg(epp_pkg::REG_SCALE_THR, $urandom_range(0, 255));
		write_reg(IDX_SPARE_LO, $urandom);
		write_reg(IDX_SPARE_HI, $urandom);
		run_random(200, 1'b1);

		write_reg(epp_pkg::REG_DET_THR, $urandom);
		write_reg(epp_pkg::REG_SCALE_THR, epp_pkg::CFG_DATA_W'(
			{$urandom_range(0, 65535), 16'h0000} | $urandom_range(0, 4096)));
		run_random(150, 1'b0);

		write_reg(epp_pkg::REG_DET_THR, 32'd0);
		write_reg(epp_pkg::REG_SCALE_THR, 32'd0);
		run_random(180, 1'b0);

		$display("Covered %0d result transfers (%0d valid) over six threshold settings,",
			n_results, n_valid);
		$display("with bursty input, receiver stalls and two long output hold-offs.");
		if (errors == 0 && expected_proj.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_proj.size());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
